### hdl/brt_pkg.sv
// ----------------------------------------------------------------------------
// brt_pkg
// Shared types, codes and helpers of the bandwidth reservation table.
// ----------------------------------------------------------------------------
`default_nettype none

package brt_pkg;

    localparam int unsigned DEF_TABLE_ENTRIES = 64;
    localparam int unsigned DEF_NUM_IFACES    = 4;
    localparam int unsigned DEF_SWEEP_TICKS   = 10;
    localparam logic [15:0] DEFAULT_HOLD_RST  = 16'd60;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_RESERVE = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INSUF     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_CAP0  = 3'd0,
        REG_CAP1  = 3'd1,
        REG_CAP2  = 3'd2,
        REG_CAP3  = 3'd3,
        REG_HOLD  = 3'd4
    } t_reg_idx;

    // one table entry as stored in the memory
    typedef struct packed {
        logic [1:0]  iface;
        logic [15:0] user;
        logic [15:0] task_id;
        logic [31:0] amount;
        logic [31:0] expiry;
    } t_entry;

    // configuration registers as seen by the core
    typedef struct packed {
        logic [3:0][31:0] cap;
        logic [15:0]      hold;
    } t_cfg;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sat_sub32(input logic [31:0] a, input logic [31:0] b);
        return (b > a) ? 32'd0 : a - b;
    endfunction

endpackage

`default_nettype wire

### hdl/brt_table_mem.sv
// ----------------------------------------------------------------------------
// brt_table_mem
// Single-port flow table memory, one registered read per cycle plus an optional write to the same address.
// ----------------------------------------------------------------------------
`default_nettype none

module brt_table_mem #(
    parameter int unsigned ENTRIES = brt_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [$clog2(ENTRIES)-1:0]   i_addr,
    input  wire brt_pkg::t_entry              i_wdata,
    output brt_pkg::t_entry                   o_rdata
);
    import brt_pkg::*;

    t_entry r_mem [ENTRIES];

    // optional write, read data registered every cycle (old contents on a write)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

### hdl/brt_cfg_regs.sv
// ----------------------------------------------------------------------------
// brt_cfg_regs
// Capacity and default hold registers behind the configuration write port.
// ----------------------------------------------------------------------------
`default_nettype none

module brt_cfg_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output brt_pkg::t_cfg    o_cfg
);
    import brt_pkg::*;

    t_cfg r_cfg;

    assign o_cfg = r_cfg;

    // register write decode, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cap  <= '0;
            r_cfg.hold <= DEFAULT_HOLD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CAP0: r_cfg.cap[0] <= i_cfg_data;
                REG_CAP1: r_cfg.cap[1] <= i_cfg_data;
                REG_CAP2: r_cfg.cap[2] <= i_cfg_data;
                REG_CAP3: r_cfg.cap[3] <= i_cfg_data;
                REG_HOLD: r_cfg.hold   <= i_cfg_data[15:0];
                default:  ;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/bandwidth_reservation_table_core.sv
// ----------------------------------------------------------------------------
// bandwidth_reservation_table_core
// Admission control over per-interface link capacity with a flow table.
// ----------------------------------------------------------------------------
// Every command (tick, reserve, release, query) walks the whole flow table
// through the single read port of the table memory, one entry per cycle,
// then steps through the base, execute and headroom states to the result
// register, plus any wait on the output side; the next input is taken
// once the result is registered. Entry valid bits are flip-flops cleared by
// reset, so no clearing pass is needed. Configuration writes are always
// ready and take effect on the next cycle.
`default_nettype none

module bandwidth_reservation_table_core #(
    parameter int unsigned TABLE_ENTRIES = brt_pkg::DEF_TABLE_ENTRIES,
    parameter int unsigned NUM_IFACES    = brt_pkg::DEF_NUM_IFACES,
    parameter int unsigned SWEEP_TICKS   = brt_pkg::DEF_SWEEP_TICKS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    // command input
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [1:0]         i_if_index,
    input  wire logic [15:0]        i_user_id,
    input  wire logic [15:0]        i_task_id,
    input  wire logic [31:0]        i_amount,
    input  wire logic [15:0]        i_hold_time,
    // result output
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_status,
    output logic                    o_fits,
    output logic                    o_flow_found,
    output logic [31:0]             o_flow_amount,
    output logic [31:0]             o_reserved_total,
    output logic signed [32:0]      o_available,
    output logic [6:0]              o_expired_count
);
    import brt_pkg::*;

    localparam int unsigned AW  = $clog2(TABLE_ENTRIES);
    localparam int unsigned IFW = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
    localparam logic [AW:0]  LAST_IDX   = (AW+1)'(TABLE_ENTRIES - 1);
    localparam logic [AW:0]  ENTRY_CNT  = (AW+1)'(TABLE_ENTRIES);
    localparam logic [7:0]   SWEEP_LOAD = 8'(SWEEP_TICKS);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_BASE, S_EXEC, S_AVAIL, S_DONE
    } t_state;

    t_state              r_state;
    t_cfg                cfg;

    // item registers
    t_cmd                r_cmd;
    logic [1:0]          r_ifc;
    logic                r_ifok;
    logic [15:0]         r_user;
    logic [15:0]         r_task;
    logic [31:0]         r_amount;
    logic [15:0]         r_hold;

    // time state
    logic [31:0]         r_now;
    logic [7:0]          r_countdown;
    logic                r_sweep;

    // table state outside the memory
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0]         r_sum [NUM_IFACES];

    // scan state
    logic [AW:0]         r_rd_cnt;
    logic                r_cmp_v;
    logic [AW-1:0]       r_cmp_idx;
    logic                r_found;
    logic [AW-1:0]       r_idx;
    logic [31:0]         r_old_amt;
    logic                r_removed;
    logic                r_free_ok;
    logic [AW-1:0]       r_free_idx;
    logic [6:0]          r_expired;

    // decision state
    logic [31:0]         r_base;
    t_status             r_status;
    logic                r_fits;
    logic                r_fits_set;
    logic [31:0]         r_flow_amt;
    logic signed [32:0]  r_avail;

    // memory port
    logic                mem_we;
    logic [AW-1:0]       mem_addr;
    t_entry              mem_wdata;
    t_entry              mem_rdata;

    logic                hit;
    logic                ent_v;
    logic                expired_now;
    logic [31:0]         cap_cur;
    logic [31:0]         sum_cur;
    logic signed [32:0]  res_av;
    logic                res_fits;
    logic [31:0]         hold_eff;
    logic [31:0]         flow_keep;
    logic                res_load;

    brt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    brt_table_mem #(.ENTRIES(TABLE_ENTRIES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);

    // capacity and sum of the addressed interface, zero when out of range
    always_comb begin
        cap_cur = r_ifok ? cfg.cap[r_ifc] : 32'd0;
        sum_cur = r_ifok ? r_sum[r_ifc[IFW-1:0]] : 32'd0;
    end

    // entry compare on the registered read data
    always_comb begin
        ent_v       = r_valid[r_cmp_idx];
        hit         = ent_v && r_ifok && (mem_rdata.iface == r_ifc) &&
                      (mem_rdata.user == r_user) && (mem_rdata.task_id == r_task);
        expired_now = r_sweep && ent_v && (mem_rdata.expiry <= r_now);
    end

    // admission check for reserve
    always_comb begin
        res_av    = $signed({1'b0, cap_cur}) - $signed({1'b0, r_base});
        res_fits  = r_ifok && (res_av >= $signed({1'b0, r_amount}));
        hold_eff  = (r_hold != 16'd0) ? {16'd0, r_hold} : {16'd0, cfg.hold};
        flow_keep = (r_found && !r_removed) ? r_old_amt : 32'd0;
        res_load  = (r_state == S_DONE) && (!o_valid || i_ready);
    end

    // memory address, write on a granted reserve
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_rd_cnt[AW-1:0];
        mem_wdata = '{iface: r_ifc, user: r_user, task_id: r_task,
                      amount: r_amount, expiry: sat_add32(r_now, hold_eff)};
        if (r_state == S_EXEC && r_cmd == CMD_RESERVE && res_fits &&
            (r_found || r_free_ok)) begin
            mem_we   = 1'b1;
            mem_addr = r_found ? r_idx : r_free_idx;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_now       <= '0;
            r_countdown <= SWEEP_LOAD;
            r_cmp_v     <= 1'b0;
            o_valid     <= 1'b0;
            for (int k = 0; k < NUM_IFACES; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            // result valid, set on load, cleared once taken
            if (res_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd      <= t_cmd'(i_cmd);
                        r_ifc      <= i_if_index;
                        r_ifok     <= ({30'd0, i_if_index} < 32'(NUM_IFACES));
                        r_user     <= i_user_id;
                        r_task     <= i_task_id;
                        r_amount   <= i_amount;
                        r_hold     <= i_hold_time;
                        r_sweep    <= 1'b0;
                        r_rd_cnt   <= '0;
                        r_cmp_v    <= 1'b0;
                        r_found    <= 1'b0;
                        r_removed  <= 1'b0;
                        r_free_ok  <= 1'b0;
                        r_expired  <= '0;
                        r_fits_set <= 1'b0;
                        r_status   <= ST_OK;
                        if (t_cmd'(i_cmd) == CMD_TICK) begin
                            r_now <= sat_add32(r_now, 32'd1);
                            if (r_countdown > 8'd1) begin
                                r_countdown <= r_countdown - 8'd1;
                            end else begin
                                r_countdown <= SWEEP_LOAD;
                                r_sweep     <= 1'b1;
                            end
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue one read per cycle, compare the one read before
                    r_cmp_v   <= (r_rd_cnt < ENTRY_CNT);
                    r_cmp_idx <= r_rd_cnt[AW-1:0];
                    if (r_rd_cnt < ENTRY_CNT) begin
                        r_rd_cnt <= r_rd_cnt + 1'b1;
                    end
                    if (r_cmp_v) begin
                        if (hit && !r_found) begin
                            r_found   <= 1'b1;
                            r_idx     <= r_cmp_idx;
                            r_old_amt <= mem_rdata.amount;
                            r_removed <= expired_now;
                        end
                        if (!ent_v && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_cmp_idx;
                        end
                        if (expired_now) begin
                            r_valid[r_cmp_idx] <= 1'b0;
                            r_sum[mem_rdata.iface[IFW-1:0]] <=
                                sat_sub32(r_sum[mem_rdata.iface[IFW-1:0]], mem_rdata.amount);
                            r_expired <= r_expired + 7'd1;
                        end
                        // read counter is past the end here, so compare valid drops
                        if ({1'b0, r_cmp_idx} == LAST_IDX) begin
                            r_state <= S_BASE;
                        end
                    end
                end
                S_BASE: begin
                    r_base  <= sat_sub32(sum_cur, r_found ? r_old_amt : 32'd0);
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    unique case (r_cmd)
                        CMD_RESERVE: begin
                            r_fits_set <= 1'b1;
                            r_fits     <= res_fits;
                            if (!res_fits) begin
                                r_status   <= ST_INSUF;
                                r_flow_amt <= flow_keep;
                            end else if (!r_found && !r_free_ok) begin
                                r_status   <= ST_FULL;
                                r_flow_amt <= flow_keep;
                            end else begin
                                r_valid[mem_addr]        <= 1'b1;
                                r_sum[r_ifc[IFW-1:0]]    <= sat_add32(r_base, r_amount);
                                r_flow_amt               <= r_amount;
                            end
                        end
                        CMD_RELEASE: begin
                            if (!r_found) begin
                                r_status   <= ST_NOT_FOUND;
                                r_flow_amt <= flow_keep;
                            end else begin
                                r_sum[r_ifc[IFW-1:0]] <= sat_sub32(sum_cur, r_old_amt);
                                r_valid[r_idx]        <= 1'b0;
                                r_flow_amt            <= 32'd0;
                            end
                        end
                        default: r_flow_amt <= flow_keep;
                    endcase
                    r_state <= S_AVAIL;
                end
                S_AVAIL: begin
                    r_avail <= $signed({1'b0, cap_cur}) - $signed({1'b0, sum_cur});
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // result register, load once the previous one is taken
                    if (res_load) begin
                        o_status         <= r_status;
                        o_fits           <= r_fits_set ? r_fits :
                                            (r_avail >= $signed({1'b0, r_amount}));
                        o_flow_found     <= r_found;
                        o_flow_amount    <= r_flow_amt;
                        o_reserved_total <= sum_cur;
                        o_available      <= r_avail;
                        o_expired_count  <= r_expired;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // the memory is written only while executing a reserve
    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_EXEC && r_cmd == CMD_RESERVE))
        else $error("table write outside reserve execution");

    // an accepted command always starts a table scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_SCAN))
        else $error("accepted command did not start a scan");

    // the sweep never removes more entries than the table holds
    a_expired_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_expired} <= 8'(TABLE_ENTRIES)))
        else $error("expired count beyond table size");

    // no result is produced while the scan is still running
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !o_valid) |=> !o_valid)
        else $error("result raised during scan");

endmodule

`default_nettype wire

### test/bandwidth_reservation_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bandwidth_reservation_table_core_tb
// Self-checking bench: a predictor of the flow table and the per-interface
// sums computes every result, which the monitor compares field by field.
// Directed admission, release and sweep cases come first, then random traffic
// over a small key space under phases of input idling and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module bandwidth_reservation_table_core_tb;
    import brt_pkg::*;

    localparam int ENTRIES = 64;
    localparam int SWEEP   = 10;
    localparam int LIMIT   = 2000000;

    typedef struct packed {
        t_cmd        cmd;
        logic [1:0]  ifc;
        logic [15:0] user;
        logic [15:0] tsk;
        logic [31:0] amount;
        logic [15:0] hold;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        fits;
        logic        found;
        logic [31:0] flow_amt;
        logic [31:0] total;
        logic [32:0] avail;
        logic [6:0]  expired;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_cmd = '0;
    logic [1:0] i_if_index = '0;
    logic [15:0] i_user_id = '0;
    logic [15:0] i_task_id = '0;
    logic [31:0] i_amount = '0;
    logic [15:0] i_hold_time = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [1:0] o_status;
    logic o_fits;
    logic o_flow_found;
    logic [31:0] o_flow_amount;
    logic [31:0] o_reserved_total;
    logic signed [32:0] o_available;
    logic [6:0] o_expired_count;

    bandwidth_reservation_table_core DUT (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] cap_q [4];
    logic [15:0] hold_q;
    logic        tv [ENTRIES];
    logic [1:0]  tif [ENTRIES];
    logic [15:0] tus [ENTRIES];
    logic [15:0] tta [ENTRIES];
    logic [31:0] tam [ENTRIES];
    logic [31:0] tex [ENTRIES];
    logic [31:0] rsum [4];
    logic [31:0] now_q;
    int          countdown;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   errors = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_off = 0;
    bit   hold_start = 0;
    bit   in_taken = 0;
    longint cycles = 0;

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sub_floor(logic [31:0] a, logic [31:0] b);
        return (b > a) ? 32'd0 : a - b;
    endfunction

    function automatic int lookup_flow(logic [1:0] f, logic [15:0] u, logic [15:0] t);
        for (int i = 0; i < ENTRIES; i++)
            if (tv[i] && tif[i] == f && tus[i] == u && tta[i] == t) return i;
        return -1;
    endfunction

    function automatic logic signed [33:0] headroom(logic [1:0] f);
        return $signed({2'b0, cap_q[f]}) - $signed({2'b0, rsum[f]});
    endfunction

    // admission and sweep predictor
    task automatic admit(input t_req r);
        t_res e;
        int idx, slot;
        logic [31:0] base;
        logic signed [33:0] av;
        logic fits_done;
        e = '0;
        fits_done = 0;
        idx = lookup_flow(r.ifc, r.user, r.tsk);
        e.found = idx >= 0;
        case (r.cmd)
            CMD_TICK: begin
                now_q = add_sat(now_q, 1);
                if (countdown > 1) countdown--;
                else begin
                    countdown = SWEEP;
                    for (int i = 0; i < ENTRIES; i++)
                        if (tv[i] && tex[i] <= now_q) begin
                            rsum[tif[i]] = sub_floor(rsum[tif[i]], tam[i]);
                            tv[i] = 0;
                            e.expired++;
                        end
                end
            end
            CMD_RESERVE: begin
                fits_done = 1;
                base = sub_floor(rsum[r.ifc], e.found ? tam[idx] : 32'd0);
                av = $signed({2'b0, cap_q[r.ifc]}) - $signed({2'b0, base});
                e.fits = av >= $signed({2'b0, r.amount});
                if (!e.fits) e.status = ST_INSUF;
                else begin
                    slot = idx;
                    if (slot < 0)
                        for (int i = ENTRIES - 1; i >= 0; i--) if (!tv[i]) slot = i;
                    if (slot < 0) e.status = ST_FULL;
                    else begin
                        tv[slot] = 1; tif[slot] = r.ifc; tus[slot] = r.user;
                        tta[slot] = r.tsk; tam[slot] = r.amount;
                        tex[slot] = add_sat(now_q, r.hold != 0 ? {16'd0, r.hold}
                                                               : {16'd0, hold_q});
                        rsum[r.ifc] = add_sat(base, r.amount);
                    end
                end
            end
            CMD_RELEASE: begin
                if (!e.found) e.status = ST_NOT_FOUND;
                else begin
                    rsum[r.ifc] = sub_floor(rsum[r.ifc], tam[idx]);
                    tv[idx] = 0;
                end
            end
            default: ;
        endcase
        if (!fits_done) e.fits = headroom(r.ifc) >= $signed({2'b0, r.amount});
        idx = lookup_flow(r.ifc, r.user, r.tsk);
        e.flow_amt = idx >= 0 ? tam[idx] : 32'd0;
        e.total = rsum[r.ifc];
        e.avail = headroom(r.ifc);
        expected_results.insert(expected_results.size(), e);
    endtask

    task automatic report(input string what, input logic [32:0] got, input logic [32:0] exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        errors++;
    endtask

    // driver
    always @(negedge i_clk) begin
        t_req r;
        if (i_rst_n) begin
            if (in_taken) begin
                admit(pending_reqs.pop_front());
            end
            if (in_taken || !i_valid) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    r = pending_reqs[0];
                    i_valid <= 1'b1;
                    i_cmd <= r.cmd; i_if_index <= r.ifc; i_user_id <= r.user;
                    i_task_id <= r.tsk; i_amount <= r.amount; i_hold_time <= r.hold;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= !hold_off && $urandom_range(99) >= stall_pct;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (hold_start);
        hold_off = 1;
        repeat (300) @(posedge i_clk);
        hold_off = 0;
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        cycles <= cycles + 1;
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("mismatch: result with nothing expected");
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_status != e.status) report("status", o_status, e.status);
                if (o_fits != e.fits) report("fits", o_fits, e.fits);
                if (o_flow_found != e.found) report("flow_found", o_flow_found, e.found);
                if (o_flow_amount != e.flow_amt)
                    report("flow_amount", o_flow_amount, e.flow_amt);
                if (o_reserved_total != e.total)
                    report("reserved_total", o_reserved_total, e.total);
                if (o_available != e.avail) report("available", o_available, e.avail);
                if (o_expired_count != e.expired)
                    report("expired_count", o_expired_count, e.expired);
            end
        end
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_req(input t_cmd c, input logic [1:0] f, input logic [15:0] u,
                            input logic [15:0] t, input logic [31:0] a,
                            input logic [15:0] h);
        t_req r;
        r.cmd = c; r.ifc = f; r.user = u; r.tsk = t; r.amount = a; r.hold = h;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_HOLD) hold_q = val[15:0];
        else cap_q[idx] = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until all traffic is through, then let the pipeline drain
    task automatic drain;
        while (pending_reqs.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic random_traffic(input int n);
        t_cmd c;
        logic [31:0] a;
        for (int k = 0; k < n; k++) begin
            c = t_cmd'($urandom_range(3));
            case ($urandom_range(3))
                0: a = $urandom;
                1: a = $urandom_range(2000);
                2: a = 32'hFFFF_FFFF - $urandom_range(3);
                default: a = $urandom_range(300);
            endcase
            push_req(c, 2'($urandom_range(3)),
                     16'($urandom_range(9) == 0 ? $urandom : $urandom_range(5)),
                     16'($urandom_range(9) == 0 ? $urandom : $urandom_range(12)), a,
                     16'($urandom_range(2) == 0 ? 0 :
                         ($urandom_range(5) == 0 ? $urandom : $urandom_range(40))));
        end
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) tv[i] = 0;
        for (int i = 0; i < 4; i++) begin cap_q[i] = 0; rsum[i] = 0; end
        hold_q = DEFAULT_HOLD_RST;
        now_q = 0;
        countdown = SWEEP;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero capacity, then extremes of capacity
        push_req(CMD_RESERVE, 0, 1, 1, 0, 0);
        push_req(CMD_RESERVE, 1, 1, 1, 1, 0);
        push_req(CMD_QUERY, 2, 0, 0, 32'hFFFF_FFFF, 0);
        drain();
        write_reg(REG_CAP0, 32'hFFFF_FFFF);
        write_reg(REG_CAP1, 1000);
        write_reg(REG_CAP2, 0);
        write_reg(REG_CAP3, 500);
        write_reg(REG_HOLD, 0);
        push_req(CMD_RESERVE, 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        push_req(CMD_RESERVE, 0, 0, 0, 1, 0);
        push_req(CMD_RESERVE, 1, 2, 3, 600, 5);
        push_req(CMD_RESERVE, 1, 2, 4, 500, 5);
        push_req(CMD_RESERVE, 1, 2, 3, 900, 0);
        push_req(CMD_RESERVE, 1, 2, 3, 1001, 7);
        push_req(CMD_QUERY, 1, 2, 3, 100, 0);
        push_req(CMD_RELEASE, 1, 2, 3, 0, 0);
        push_req(CMD_RELEASE, 1, 2, 3, 0, 0);
        push_req(CMD_RESERVE, 3, 9, 9, 500, 0);
        for (int i = 0; i < SWEEP; i++) push_req(CMD_TICK, 0, 0, 0, 0, 0);
        push_req(CMD_QUERY, 3, 9, 9, 1, 0);
        drain();

        // fill the table and hit table full
        write_reg(REG_CAP3, 32'hFFFF_FFFF);
        write_reg(REG_HOLD, 16'hFFFF);
        for (int i = 0; i < ENTRIES + 2; i++) push_req(CMD_RESERVE, 3, 7, 16'(i), 1, 0);
        drain();
        for (int i = 0; i < ENTRIES; i += 2) push_req(CMD_RELEASE, 3, 7, 16'(i), 0, 0);
        drain();

        // random phases with varied config
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_CAP0, ph == 4 ? 32'd0 : $urandom_range(5000));
            write_reg(REG_CAP1, $urandom);
            write_reg(REG_CAP2, ph == 2 ? 32'hFFFF_FFFF : $urandom_range(3000));
            write_reg(REG_CAP3, $urandom_range(800));
            write_reg(REG_HOLD, ph == 3 ? 16'd1 : $urandom_range(1, 50));
            case (ph)
                1: begin idle_pct = 72; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 72; end
                3: begin idle_pct = 26; stall_pct = 26; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            random_traffic(90);
            if (ph == 0) begin
                hold_start = 1;
            end
            drain();
        end
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

### bandwidth_reservation_table_core.f
hdl/brt_pkg.sv
hdl/brt_table_mem.sv
hdl/brt_cfg_regs.sv
hdl/bandwidth_reservation_table_core.sv
test/bandwidth_reservation_table_core_tb.sv
